// ===== hw/rtl/csv_record_tokenizer_unit_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef CSV_RECORD_TOKENIZER_UNIT_DEFINES_SVH
`define CSV_RECORD_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define CSV_RT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define CSV_RT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/csv_rt_pkg.sv =====
// Types, constants and helpers for the CSV record tokenizer.
`default_nettype none
package csv_rt_pkg;
	localparam int MAX_FIELDS = 255;
	localparam logic [7:0] FIELD_CAP = (MAX_FIELDS < 255) ? 8'(MAX_FIELDS) : 8'd255;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_FIELD_END = 2'd1,
		KIND_ROW_END   = 2'd2,
		KIND_STATUS    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_out;
		logic [7:0] row_fields;
		logic       width_error;
		logic [7:0] fewest_fields;
		logic [7:0] most_fields;
		logic       last_of_run;
	} result_t;

	// Results of one item, handed from the core to the output queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v >= FIELD_CAP) ? FIELD_CAP : v + 8'd1;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/csv_rt_in_stage.sv =====
// Input register stage: holds one byte transaction until the core takes it.
`default_nettype none
module csv_rt_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_eoi,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1,
	output logic            eoi_s1
);
	import csv_rt_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eoi_s1  <= in_eoi;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/csv_rt_core.sv =====
// Tokenizer state and the per-byte decision logic.
`default_nettype none
module csv_rt_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] byte_s1,
	input  wire logic       eoi_s1,
	output csv_rt_pkg::push_t push
);
	import csv_rt_pkg::*;

	logic       quoted_q, pending_q, empty_q, line_q, any_q;
	logic [7:0] fields_q, min_q, max_q;
	logic       quoted_n, pending_n, empty_n, line_n, any_n;
	logic [7:0] fields_n, min_n, max_n;

	logic [7:0] row_n, min_upd, max_upd, fw, mo;
	logic       any_f, q_eff, handled;
	result_t    row_res, char_res, stat_res, fe_res;

	always_comb begin
		quoted_n  = quoted_q;
		pending_n = pending_q;
		empty_n   = empty_q;
		line_n    = line_q;
		any_n     = any_q;
		fields_n  = fields_q;
		min_n     = min_q;
		max_n     = max_q;
		q_eff     = quoted_q;
		handled   = 1'b0;
		push      = '0;

		row_n   = sat_inc(fields_q);
		min_upd = (row_n < min_q) ? row_n : min_q;
		max_upd = (row_n > max_q) ? row_n : max_q;

		row_res            = '0;
		row_res.kind       = KIND_ROW_END;
		row_res.row_fields = row_n;
		char_res           = '0;
		char_res.kind      = KIND_CHAR;
		char_res.char_out  = byte_s1;
		fe_res             = '0;
		fe_res.kind        = KIND_FIELD_END;

		// status sees the row closed by this same transaction
		fw    = line_q ? min_upd : min_q;
		mo    = line_q ? max_upd : max_q;
		any_f = any_q || line_q;
		stat_res             = '0;
		stat_res.kind        = KIND_STATUS;
		stat_res.last_of_run = 1'b1;
		if (any_f) begin
			stat_res.width_error   = (fw != mo);
			stat_res.fewest_fields = fw;
			stat_res.most_fields   = mo;
		end

		if (eoi_s1) begin
			if (line_q) begin
				push.count  = 2'd2;
				push.first  = row_res;
				push.second = stat_res;
			end else begin
				push.count = 2'd1;
				push.first = stat_res;
			end
			quoted_n  = 1'b0;
			pending_n = 1'b0;
			empty_n   = 1'b1;
			line_n    = 1'b0;
			any_n     = 1'b0;
			fields_n  = 8'd0;
			min_n     = 8'hFF;
			max_n     = 8'd0;
		end else begin
			if (pending_q) begin
				pending_n = 1'b0;
				if (byte_s1 == CH_QUOTE) begin
					// doubled quote inside quotes
					line_n     = 1'b1;
					empty_n    = 1'b0;
					push.count = 2'd1;
					push.first = char_res;
					handled    = 1'b1;
				end else begin
					q_eff    = 1'b0;
					quoted_n = 1'b0;
				end
			end
			if (!handled) begin
				if (byte_s1 == CH_LF) begin
					push.count = 2'd1;
					push.first = row_res;
					min_n      = min_upd;
					max_n      = max_upd;
					any_n      = 1'b1;
					fields_n   = 8'd0;
					quoted_n   = 1'b0;
					pending_n  = 1'b0;
					empty_n    = 1'b1;
					line_n     = 1'b0;
				end else begin
					line_n = 1'b1;
					if (byte_s1 == CH_COMMA && !q_eff) begin
						fields_n   = row_n;
						empty_n    = 1'b1;
						push.count = 2'd1;
						push.first = fe_res;
					end else if (byte_s1 == CH_QUOTE) begin
						if (q_eff) begin
							pending_n = 1'b1;
						end else if (empty_q) begin
							quoted_n = 1'b1;
						end else begin
							push.count = 2'd1;
							push.first = char_res;
						end
					end else if (byte_s1 != CH_CR) begin
						empty_n    = 1'b0;
						push.count = 2'd1;
						push.first = char_res;
					end
				end
			end
			push.first.last_of_run = (push.count != 2'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoted_q  <= 1'b0;
			pending_q <= 1'b0;
			empty_q   <= 1'b1;
			line_q    <= 1'b0;
			any_q     <= 1'b0;
			fields_q  <= 8'd0;
			min_q     <= 8'hFF;
			max_q     <= 8'd0;
		end else if (advance) begin
			quoted_q  <= quoted_n;
			pending_q <= pending_n;
			empty_q   <= empty_n;
			line_q    <= line_n;
			any_q     <= any_n;
			fields_q  <= fields_n;
			min_q     <= min_n;
			max_q     <= max_n;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/csv_rt_out_fifo.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
`default_nettype none
module csv_rt_out_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_en,
	input  wire csv_rt_pkg::push_t push,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output csv_rt_pkg::result_t    out_res
);
	import csv_rt_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q, rd_q;
	logic [FIFO_CW-1:0]   count_q;
	logic [FIFO_CW-1:0]   n_in;
	logic                 pop;

	// room for the largest burst one transaction can cause
	assign room      = count_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign n_in      = push_en ? FIFO_CW'(push.count) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(n_in);
			rd_q    <= rd_q + FIFO_AW'(pop);
			count_q <= count_q + n_in - FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_en && push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push_en && push.count == 2'd2) begin
			mem_q[wr_q + FIFO_AW'(1)] <= push.second;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/csv_record_tokenizer_unit.sv =====
// CSV record tokenizer: one text byte in per cycle, field and row tokens out.
// Bytes are held in the input stage, then decoded by the core into the queue.
// Throughput: one byte per cycle; end of input gives up to two results, drained
// one per cycle from a four-entry queue, which throttles input when nearly full.
// Reset: arst_n clears all parse state, row statistics and the queue at once.
`default_nettype none
`include "csv_record_tokenizer_unit_defines.svh"
module csv_record_tokenizer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] byte_value
	input  wire logic        s_axis_tlast,  // end_of_input
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // char_out, row_fields, width_error,
	                                        // fewest_fields, most_fields, zero pad
	output logic [1:0]       m_axis_tuser,  // kind
	output logic             m_axis_tlast   // last_of_run
);
	import csv_rt_pkg::*;

	logic       valid_s1, eoi_s1, advance, room;
	logic [7:0] byte_s1;
	push_t      push;
	result_t    out_res;

	assign advance = valid_s1 && room;

	csv_rt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_eoi   (s_axis_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.eoi_s1   (eoi_s1)
	);

	csv_rt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.eoi_s1  (eoi_s1),
		.push    (push)
	);

	csv_rt_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (advance),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {7'd0, out_res.most_fields, out_res.fewest_fields,
		out_res.width_error, out_res.row_fields, out_res.char_out};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last_of_run;

	`CSV_RT_ASSERT_IMPL(a_status_last, m_axis_tvalid && m_axis_tuser == KIND_STATUS, m_axis_tlast, "status result without tlast")
	`CSV_RT_ASSERT_IMPL(a_row_nonzero, m_axis_tvalid && m_axis_tuser == KIND_ROW_END, m_axis_tdata[15:8] != 8'd0, "row ended with zero fields")
	`CSV_RT_ASSERT_IMPL(a_pair_order, advance && push.count == 2'd2, push.first.kind == KIND_ROW_END && push.second.kind == KIND_STATUS && eoi_s1, "bad two-result transaction")
	`CSV_RT_ASSERT_NEXT(a_result_shows, advance && push.count != 2'd0, m_axis_tvalid, "queued result not presented")
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the CSV record tokenizer: directed and random text against a predictor.
module tb_top;
	import csv_rt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 520;
	localparam int HOLD_CYCLES = 80;

	class csv_token_scoreboard;
		result_t exp_tokens[$];
		result_t step_tokens[$];
		int errors;
		logic quoted;
		logic quote_held;
		logic field_empty;
		logic line_open;
		logic seen_row;
		logic [7:0] commas;
		logic [7:0] fewest;
		logic [7:0] most;

		function new();
			errors = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			quoted = 1'b0;
			quote_held = 1'b0;
			field_empty = 1'b1;
			line_open = 1'b0;
			seen_row = 1'b0;
			commas = 8'd0;
			fewest = 8'hFF;
			most = 8'd0;
		endfunction

		function logic [7:0] bump(logic [7:0] v);
			return (v >= FIELD_CAP) ? FIELD_CAP : v + 8'd1;
		endfunction

		function void add(kind_t k, logic [7:0] ch, logic [7:0] rf, logic we,
				logic [7:0] fw, logic [7:0] mo);
			result_t r;
			r.kind = k;
			r.char_out = ch;
			r.row_fields = rf;
			r.width_error = we;
			r.fewest_fields = fw;
			r.most_fields = mo;
			r.last_of_run = 1'b0;
			step_tokens = {step_tokens, r};
		endfunction

		// the newline token also closes the row's last field
		function void close_row();
			logic [7:0] n;
			n = bump(commas);
			if (n < fewest)
				fewest = n;
			if (n > most)
				most = n;
			seen_row = 1'b1;
			add(KIND_ROW_END, 8'd0, n, 1'b0, 8'd0, 8'd0);
			commas = 8'd0;
			quoted = 1'b0;
			quote_held = 1'b0;
			field_empty = 1'b1;
			line_open = 1'b0;
		endfunction

		function void note_input(logic [7:0] b, logic eoi);
			step_tokens.delete();
			if (eoi) begin
				quote_held = 1'b0;
				quoted = 1'b0;
				if (line_open)
					close_row();
				if (seen_row)
					add(KIND_STATUS, 8'd0, 8'd0, fewest != most, fewest, most);
				else
					add(KIND_STATUS, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
				clear_stream();
			end else if (quote_held && b == CH_QUOTE) begin
				// doubled quote inside quotes: one literal quote
				quote_held = 1'b0;
				line_open = 1'b1;
				field_empty = 1'b0;
				add(KIND_CHAR, CH_QUOTE, 8'd0, 1'b0, 8'd0, 8'd0);
			end else begin
				if (quote_held) begin
					quote_held = 1'b0;
					quoted = 1'b0;
				end
				if (b == CH_LF) begin
					close_row();
				end else begin
					line_open = 1'b1;
					if (b == CH_COMMA && !quoted) begin
						commas = bump(commas);
						field_empty = 1'b1;
						add(KIND_FIELD_END, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
					end else if (b == CH_QUOTE) begin
						if (quoted)
							quote_held = 1'b1;
						else if (field_empty)
							quoted = 1'b1;
						else
							add(KIND_CHAR, b, 8'd0, 1'b0, 8'd0, 8'd0);
					end else if (b != CH_CR) begin
						field_empty = 1'b0;
						add(KIND_CHAR, b, 8'd0, 1'b0, 8'd0, 8'd0);
					end
				end
			end
			if (step_tokens.size() > 0)
				step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
			exp_tokens = {exp_tokens, step_tokens};
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_token(logic [1:0] k, logic [39:0] d, logic l);
			result_t e;
			if (exp_tokens.size() == 0) begin
				report($sformatf("unexpected token kind %0d data %h last %b", k, d, l));
			end else begin
				e = exp_tokens.pop_front();
				if (k !== e.kind || d[7:0] !== e.char_out || d[15:8] !== e.row_fields ||
						d[16] !== e.width_error || d[24:17] !== e.fewest_fields ||
						d[32:25] !== e.most_fields || d[39:33] !== 7'd0 ||
						l !== e.last_of_run)
					report($sformatf({"got kind %0d data %h last %b, want kind %0d ch %h",
						" row %0d err %b few %0d most %0d last %b"},
						k, d, l, e.kind, e.char_out, e.row_fields, e.width_error,
						e.fewest_fields, e.most_fields, e.last_of_run));
			end
		endtask

		function int outstanding();
			return exp_tokens.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	csv_token_scoreboard sb = new();
	int cycles = 0;
	int items_sent = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit quiet = 1'b0;

	csv_record_tokenizer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function bit rolls_idle();
		return !quiet && ($urandom_range(0, 99) < 7);
	endfunction

	// receiver: checks each output transaction, owns the long hold-off count
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_token(m_axis_tuser, m_axis_tdata, m_axis_tlast);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= arst_n && !rolls_idle();
			end
		end
	end

	task automatic send_item(logic [7:0] b, logic eoi);
		while (rolls_idle()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eoi;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(b, eoi);
		items_sent++;
	endtask

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	// stop offering until every predicted token is out, plus pipeline slack
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_row();
		int nf;
		int len;
		int r;
		logic [7:0] c;
		nf = $urandom_range(1, 6);
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				send_item(CH_COMMA, 1'b0);
			len = $urandom_range(0, 5);
			if ($urandom_range(0, 2) == 0) begin
				send_item(CH_QUOTE, 1'b0);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 9);
					case (r)
						0: send_item(CH_CR, 1'b0);
						1: send_item(CH_COMMA, 1'b0);
						2: send_item(CH_LF, 1'b0);
						3: begin
							send_item(CH_QUOTE, 1'b0);
							send_item(CH_QUOTE, 1'b0);
						end
						default: begin
							c = 8'($urandom_range(0, 255));
							send_item((c == CH_QUOTE) ? 8'h51 : c, 1'b0);
						end
					endcase
				end
				send_item(CH_QUOTE, 1'b0);
			end else begin
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 9);
					c = 8'($urandom_range(0, 255));
					if (r == 0)
						c = CH_CR;
					else if (r == 1 && i > 0)
						c = CH_QUOTE;
					else if (c == CH_COMMA || c == CH_LF || c == CH_QUOTE)
						c = 8'h7A;
					send_item(c, 1'b0);
				end
			end
		end
		if ($urandom_range(0, 1) == 0)
			send_item(CH_CR, 1'b0);
		send_item(CH_LF, 1'b0);
	endtask

	task automatic send_noise();
		int n;
		logic [7:0] c;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0: c = CH_QUOTE;
				1: c = CH_COMMA;
				2: c = CH_LF;
				3: c = CH_CR;
				default: c = 8'($urandom_range(0, 255));
			endcase
			send_item(c, 1'b0);
		end
	endtask

	initial begin
		bit held;
		bit paused;
		int mode;
		held = 1'b0;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// end of input before any row, with a junk byte alongside
		send_item(8'hFF, 1'b1);
		// doubled quote, pending quote closed by a comma, CR dropped
		send_str("\"a\"\"b\",\r\n");
		// empty line is a row of one empty field
		send_str("\n");
		// quote after a character is literal
		send_str("x\"y\n");
		// pending quote closed by newline
		send_str("\"q\"\n");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_LF, 1'b0);
		// quoted field still open at end of input, open line flushed, widths differ
		send_item(CH_QUOTE, 1'b0);
		send_item(8'h00, 1'b1);

		// one row past the field count cap
		for (int i = 0; i < 300; i++)
			send_item(CH_COMMA, 1'b0);
		send_item(CH_LF, 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);

		while (items_sent < RANDOM_ITEMS + 330) begin
			if (!held && items_sent > 450) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!paused && items_sent > 650) begin
				drain();
				paused = 1'b1;
			end
			quiet = (items_sent >= 720 && items_sent < 830);
			mode = $urandom_range(0, 99);
			if (mode < 75)
				send_row();
			else if (mode < 92)
				send_noise();
			else
				send_item(8'($urandom_range(0, 255)), 1'b1);
		end
		quiet = 1'b0;
		send_item(8'($urandom_range(0, 255)), 1'b1);
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
